FILE: hdl/vr2d_pkg.sv
// Shared constants and the arctangent table for the 2D vector rotator.
`default_nettype none

package vr2d_pkg;

   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_COORD_WIDTH   = 16;

   localparam int ANGLE_WIDTH = 16;
   // The angle moves from Q3.13 to Q2.30 by this left shift.
   localparam int ANGLE_SHIFT = 17;
   localparam int FRAC_BITS   = 30;
   localparam int CX_WIDTH    = 33;
   localparam int Z_WIDTH     = 34;
   localparam int ATAN_LEN    = 24;

   localparam logic signed [Z_WIDTH-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;

   localparam longint K_BASE     = 64'sd652032874;
   localparam longint K_FRAC     = 64'sd434688583;
   localparam longint ROUND_BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   // atan(2^-i) in Q2.30, truncated.
   function automatic logic signed [Z_WIDTH-1:0] atan_q30(input int idx);
      logic signed [Z_WIDTH-1:0] val;
      unique case (idx)
         0:       val = 34'sd843314856;
         1:       val = 34'sd497837829;
         2:       val = 34'sd263043836;
         3:       val = 34'sd133525158;
         4:       val = 34'sd67021686;
         5:       val = 34'sd33543515;
         6:       val = 34'sd16775850;
         7:       val = 34'sd8388437;
         8:       val = 34'sd4194282;
         9:       val = 34'sd2097149;
         10:      val = 34'sd1048575;
         11:      val = 34'sd524287;
         12:      val = 34'sd262143;
         13:      val = 34'sd131071;
         14:      val = 34'sd65535;
         15:      val = 34'sd32767;
         16:      val = 34'sd16383;
         17:      val = 34'sd8191;
         18:      val = 34'sd4095;
         19:      val = 34'sd2047;
         20:      val = 34'sd1023;
         21:      val = 34'sd511;
         22:      val = 34'sd255;
         23:      val = 34'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/vr2d_fold.sv
// Input stage: scales the angle to Q2.30 and folds it into minus pi/2 through pi/2.
`default_nettype none

module vr2d_fold
   import vr2d_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          valid_in,
   input  wire logic signed [COORD_WIDTH-1:0] vec_x,
   input  wire logic signed [COORD_WIDTH-1:0] vec_y,
   input  wire logic signed [ANGLE_WIDTH-1:0] angle,
   output logic                               valid_out,
   output logic signed [COORD_WIDTH-1:0]      x_out,
   output logic signed [COORD_WIDTH-1:0]      y_out,
   output logic signed [Z_WIDTH-1:0]          z_out,
   output logic                               neg_out
);

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] x_ff;
   logic signed [COORD_WIDTH-1:0] y_ff;
   logic signed [Z_WIDTH-1:0]     z_ff;
   logic signed [Z_WIDTH-1:0]     z_in;
   logic signed [Z_WIDTH-1:0]     z_scaled;
   logic                          neg_ff;
   logic                          neg_in;

   assign z_scaled = {{(Z_WIDTH-ANGLE_WIDTH-ANGLE_SHIFT){angle[ANGLE_WIDTH-1]}},
                      angle, {ANGLE_SHIFT{1'b0}}};

   // Angles past a right angle are moved by pi; the sign flip is applied at the end.
   always_comb begin
      z_in   = z_scaled;
      neg_in = 1'b0;
      if (z_scaled > HALF_PI_Q30) begin
         z_in   = z_scaled - PI_Q30;
         neg_in = 1'b1;
      end else if (z_scaled < -HALF_PI_Q30) begin
         z_in   = z_scaled + PI_Q30;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff   <= vec_x;
         y_ff   <= vec_y;
         z_ff   <= z_in;
         neg_ff <= neg_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign neg_out   = neg_ff;

endmodule

`default_nettype wire

FILE: hdl/vr2d_cordic_stage.sv
// One registered micro-rotation of the CORDIC pipeline.
`default_nettype none

module vr2d_cordic_stage
   import vr2d_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int STAGE_IDX   = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          valid_in,
   input  wire logic signed [COORD_WIDTH-1:0] x_in,
   input  wire logic signed [COORD_WIDTH-1:0] y_in,
   input  wire logic signed [CX_WIDTH-1:0]    cx_in,
   input  wire logic signed [CX_WIDTH-1:0]    cy_in,
   input  wire logic signed [Z_WIDTH-1:0]     z_in,
   input  wire logic                          neg_in,
   output logic                               valid_out,
   output logic signed [COORD_WIDTH-1:0]      x_out,
   output logic signed [COORD_WIDTH-1:0]      y_out,
   output logic signed [CX_WIDTH-1:0]         cx_out,
   output logic signed [CX_WIDTH-1:0]         cy_out,
   output logic signed [Z_WIDTH-1:0]          z_out,
   output logic                               neg_out
);

   localparam logic signed [Z_WIDTH-1:0] ATAN = atan_q30(STAGE_IDX);

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] x_ff;
   logic signed [COORD_WIDTH-1:0] y_ff;
   logic signed [CX_WIDTH-1:0]    cx_ff;
   logic signed [CX_WIDTH-1:0]    cy_ff;
   logic signed [CX_WIDTH-1:0]    cx_in_next;
   logic signed [CX_WIDTH-1:0]    cy_in_next;
   logic signed [CX_WIDTH-1:0]    dx;
   logic signed [CX_WIDTH-1:0]    dy;
   logic signed [Z_WIDTH-1:0]     z_ff;
   logic signed [Z_WIDTH-1:0]     z_in_next;
   logic                          neg_ff;

   assign dx = cy_in >>> STAGE_IDX;
   assign dy = cx_in >>> STAGE_IDX;

   always_comb begin
      if (!z_in[Z_WIDTH-1]) begin
         cx_in_next = cx_in - dx;
         cy_in_next = cy_in + dy;
         z_in_next  = z_in - ATAN;
      end else begin
         cx_in_next = cx_in + dx;
         cy_in_next = cy_in - dy;
         z_in_next  = z_in + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         cx_ff  <= cx_in_next;
         cy_ff  <= cy_in_next;
         z_ff   <= z_in_next;
         neg_ff <= neg_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign cx_out    = cx_ff;
   assign cy_out    = cy_ff;
   assign z_out     = z_ff;
   assign neg_out   = neg_ff;

endmodule

`default_nettype wire

FILE: hdl/vr2d_mult.sv
// Back end: multiplies the vector by cosine and sine, sums, and truncates toward zero.
`default_nettype none

module vr2d_mult
   import vr2d_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          valid_in,
   input  wire logic signed [COORD_WIDTH-1:0] x_in,
   input  wire logic signed [COORD_WIDTH-1:0] y_in,
   input  wire logic signed [CX_WIDTH-1:0]    cos_in,
   input  wire logic signed [CX_WIDTH-1:0]    sin_in,
   input  wire logic                          neg_in,
   output logic                               valid_out,
   output logic signed [COORD_WIDTH:0]        rot_x,
   output logic signed [COORD_WIDTH:0]        rot_y
);

   localparam int PW = COORD_WIDTH + CX_WIDTH;
   localparam int SW = PW + 1;

   logic                      prod_valid_ff;
   logic                      sum_valid_ff;
   logic                      out_valid_ff;
   logic signed [PW-1:0]      xc_ff;
   logic signed [PW-1:0]      xs_ff;
   logic signed [PW-1:0]      yc_ff;
   logic signed [PW-1:0]      ys_ff;
   logic                      neg_ff;
   logic signed [SW-1:0]      sum_x_in;
   logic signed [SW-1:0]      sum_y_in;
   logic signed [SW-1:0]      sum_x_ff;
   logic signed [SW-1:0]      sum_y_ff;
   logic signed [SW-1:0]      quot_x;
   logic signed [SW-1:0]      quot_y;
   logic signed [COORD_WIDTH:0] rot_x_ff;
   logic signed [COORD_WIDTH:0] rot_y_ff;

   // A folded angle negates both cosine and sine, which negates both sums.
   always_comb begin
      if (neg_ff) begin
         sum_x_in = SW'(ys_ff) - SW'(xc_ff);
         sum_y_in = -(SW'(xs_ff) + SW'(yc_ff));
      end else begin
         sum_x_in = SW'(xc_ff) - SW'(ys_ff);
         sum_y_in = SW'(xs_ff) + SW'(yc_ff);
      end
   end

   // Adding 2^30 - 1 to a negative sum makes the arithmetic shift round toward zero.
   assign quot_x = (sum_x_ff + (sum_x_ff[SW-1] ? SW'(ROUND_BIAS) : '0)) >>> FRAC_BITS;
   assign quot_y = (sum_y_ff + (sum_y_ff[SW-1] ? SW'(ROUND_BIAS) : '0)) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (enable) begin
         prod_valid_ff <= valid_in;
         sum_valid_ff  <= prod_valid_ff;
         out_valid_ff  <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xc_ff    <= x_in * cos_in;
         xs_ff    <= x_in * sin_in;
         yc_ff    <= y_in * cos_in;
         ys_ff    <= y_in * sin_in;
         neg_ff   <= neg_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         rot_x_ff <= quot_x[COORD_WIDTH:0];
         rot_y_ff <= quot_y[COORD_WIDTH:0];
      end
   end

   assign valid_out = out_valid_ff;
   assign rot_x     = rot_x_ff;
   assign rot_y     = rot_y_ff;

endmodule

`default_nettype wire

FILE: hdl/vector_rotate_2d.sv
// Top level of the pipelined 2D vector rotator.
`default_nettype none

// Rotates (vec_x, vec_y) by a Q3.13 angle in radians and returns the rotated vector,
// each component truncated toward zero. Cosine and sine come from a rotation-mode
// CORDIC with one register stage per iteration, so a new transfer is taken in every
// cycle while the output is not stalled. An item passes the angle fold register, one
// register per CORDIC iteration (capped at the arctangent table length), and the
// product, sum and output registers. The whole pipeline holds while a result waits on
// the output; req_tready then follows rsp_tready combinationally.
module vector_rotate_2d
   import vr2d_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // Fields from bit 0 up: vec_x, vec_y, angle, zero fill.
   input  wire logic [((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // Fields from bit 0 up: rot_x, rot_y, zero fill.
   output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] rsp_tdata
);

   localparam int NUM_ITER = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
   localparam int LATENCY  = NUM_ITER + 4;
   localparam int OCC_W    = $clog2(LATENCY + 1);
   localparam int RSP_W    = ((2*COORD_WIDTH+2+7)/8)*8;
   localparam logic signed [CX_WIDTH-1:0] K_INIT =
      CX_WIDTH'(K_BASE + (K_FRAC >>> (2*CORDIC_STAGES)));

   logic                          advance;
   logic                          valid_chain [0:NUM_ITER];
   logic signed [COORD_WIDTH-1:0] x_chain     [0:NUM_ITER];
   logic signed [COORD_WIDTH-1:0] y_chain     [0:NUM_ITER];
   logic signed [CX_WIDTH-1:0]    cx_chain    [0:NUM_ITER];
   logic signed [CX_WIDTH-1:0]    cy_chain    [0:NUM_ITER];
   logic signed [Z_WIDTH-1:0]     z_chain     [0:NUM_ITER];
   logic                          neg_chain   [0:NUM_ITER];
   logic signed [COORD_WIDTH:0]   rot_x;
   logic signed [COORD_WIDTH:0]   rot_y;
   logic [OCC_W-1:0]              occ_ff;
   logic [OCC_W-1:0]              occ_in;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   vr2d_fold #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (req_tvalid),
      .vec_x     (req_tdata[COORD_WIDTH-1:0]),
      .vec_y     (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .angle     (req_tdata[2*COORD_WIDTH+ANGLE_WIDTH-1:2*COORD_WIDTH]),
      .valid_out (valid_chain[0]),
      .x_out     (x_chain[0]),
      .y_out     (y_chain[0]),
      .z_out     (z_chain[0]),
      .neg_out   (neg_chain[0])
   );

   // Every item starts from the gain-compensated unit vector.
   assign cx_chain[0] = K_INIT;
   assign cy_chain[0] = '0;

   for (genvar i = 0; i < NUM_ITER; i++) begin : g_stage
      vr2d_cordic_stage #(
         .COORD_WIDTH (COORD_WIDTH),
         .STAGE_IDX   (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .valid_in  (valid_chain[i]),
         .x_in      (x_chain[i]),
         .y_in      (y_chain[i]),
         .cx_in     (cx_chain[i]),
         .cy_in     (cy_chain[i]),
         .z_in      (z_chain[i]),
         .neg_in    (neg_chain[i]),
         .valid_out (valid_chain[i+1]),
         .x_out     (x_chain[i+1]),
         .y_out     (y_chain[i+1]),
         .cx_out    (cx_chain[i+1]),
         .cy_out    (cy_chain[i+1]),
         .z_out     (z_chain[i+1]),
         .neg_out   (neg_chain[i+1])
      );
   end

   vr2d_mult #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (valid_chain[NUM_ITER]),
      .x_in      (x_chain[NUM_ITER]),
      .y_in      (y_chain[NUM_ITER]),
      .cos_in    (cx_chain[NUM_ITER]),
      .sin_in    (cy_chain[NUM_ITER]),
      .neg_in    (neg_chain[NUM_ITER]),
      .valid_out (rsp_tvalid),
      .rot_x     (rot_x),
      .rot_y     (rot_y)
   );

   assign rsp_tdata = RSP_W'({rot_y, rot_x});

   // Count of transfers taken in but not yet delivered.
   always_comb begin
      occ_in = occ_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(LATENCY))
      else $error("more items in flight than pipeline stages");

   a_valid_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (occ_ff != '0))
      else $error("result presented with no item in flight");

   a_empty_no_result: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |=> !rsp_tvalid)
      else $error("result appeared sooner than the pipeline latency");

endmodule

`default_nettype wire

FILE: sim/vector_rotate_2d_test.sv
// Self-checking testbench for the pipelined 2D vector rotator.
`default_nettype none

module vector_rotate_2d_test
   import vr2d_pkg::*;
;

   localparam int STAGES      = DEF_CORDIC_STAGES;
   localparam int CW          = DEF_COORD_WIDTH;
   localparam int REQ_W       = ((2*CW+ANGLE_WIDTH+7)/8)*8;
   localparam int RSP_W       = ((2*CW+2+7)/8)*8;
   localparam int LATENCY     = ((STAGES < ATAN_LEN) ? STAGES : ATAN_LEN) + 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int ANGLE_MAX   = 25736;
   // First Q3.13 angle whose Q2.30 value lies beyond pi/2.
   localparam int FOLD_ANGLE  = 12868;

   // atan(2^-i) in Q2.30, truncated toward zero.
   localparam longint ARCTAN_Q30 [ATAN_LEN] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };

   typedef struct packed {
      logic signed [CW:0] rot_y;
      logic signed [CW:0] rot_x;
   } rotated_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   rotated_type expected_rotations[$];
   rotated_type want, got;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          gap_pct        = 0;
   int          stall_pct      = 0;

   vector_rotate_2d #(
      .CORDIC_STAGES (STAGES),
      .COORD_WIDTH   (CW)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rotation of (x, y) by angle a: CORDIC cosine and sine in Q2.30, exact
   // products, then division by 2^30 truncated toward zero.
   function automatic rotated_type rotate_vector(logic signed [CW-1:0] x,
                                                 logic signed [CW-1:0] y,
                                                 logic signed [ANGLE_WIDTH-1:0] a);
      longint      z, cs, sn, dc, ds;
      longint      one;
      bit          flip;
      rotated_type r;
      one  = 64'sd1 <<< FRAC_BITS;
      z    = longint'(a) * (64'sd1 <<< ANGLE_SHIFT);
      flip = 1'b0;
      if (z > longint'(HALF_PI_Q30)) begin
         z    = z - longint'(PI_Q30);
         flip = 1'b1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
         z    = z + longint'(PI_Q30);
         flip = 1'b1;
      end
      cs = K_BASE + (K_FRAC >>> (2*STAGES));
      sn = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
         dc = sn >>> i;
         ds = cs >>> i;
         if (z >= 0) begin
            cs = cs - dc;
            sn = sn + ds;
            z  = z - ARCTAN_Q30[i];
         end else begin
            cs = cs + dc;
            sn = sn - ds;
            z  = z + ARCTAN_Q30[i];
         end
      end
      if (flip) begin
         cs = -cs;
         sn = -sn;
      end
      r.rot_x = (CW+1)'((longint'(x) * cs - longint'(y) * sn) / one);
      r.rot_y = (CW+1)'((longint'(x) * sn + longint'(y) * cs) / one);
      return r;
   endfunction

   // Predicts every accepted request and checks every accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rotations.push_back(rotate_vector(req_tdata[CW-1:0],
               req_tdata[2*CW-1:CW], req_tdata[2*CW+ANGLE_WIDTH-1:2*CW]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2*CW+1:0];
            if (expected_rotations.size() == 0) begin
               $display("%0t: unexpected result rot_x %0d rot_y %0d", $time,
                  got.rot_x, got.rot_y);
               mismatch_count++;
            end else begin
               want = expected_rotations.pop_front();
               if (got.rot_x !== want.rot_x) begin
                  $display("%0t: rot_x expected %0d, got %0d", $time,
                     want.rot_x, got.rot_x);
                  mismatch_count++;
               end
               if (got.rot_y !== want.rot_y) begin
                  $display("%0t: rot_y expected %0d, got %0d", $time,
                     want.rot_y, got.rot_y);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   // Valid stays high so back-to-back items go out without valid dropping in between.
   task automatic send_vector(input int x, input int y, input int a);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {a[ANGLE_WIDTH-1:0], y[CW-1:0], x[CW-1:0]};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid = 1'b0;
      while (expected_rotations.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int pick_coord();
      int v;
      case ($urandom_range(4))
         0: v = -32768;
         1: v = 32767;
         2: v = int'($urandom_range(8)) - 4;
         default: v = int'($urandom_range(65535)) - 32768;
      endcase
      return v;
   endfunction

   function automatic int pick_angle();
      int a;
      case ($urandom_range(7))
         0: a = FOLD_ANGLE + int'($urandom_range(6)) - 3;
         1: a = -FOLD_ANGLE + int'($urandom_range(6)) - 3;
         2: a = ($urandom_range(1) != 0) ? ANGLE_MAX : -ANGLE_MAX;
         3: a = int'($urandom_range(64)) - 32;
         default: a = int'($urandom_range(2*ANGLE_MAX)) - ANGLE_MAX;
      endcase
      return a;
   endfunction

   task automatic random_vectors(input int count, input int gaps, input int stalls);
      gap_pct   = gaps;
      stall_pct = stalls;
      for (int n = 0; n < count; n++)
         send_vector(pick_coord(), pick_coord(), pick_angle());
      wait_for_results();
   endtask

   // Extreme coordinates and angles, both sides of the pi/2 fold, the 45 degree
   // case with the largest output magnitude, and small values for truncation.
   task automatic test_directed_cases();
      gap_pct   = 0;
      stall_pct = 0;
      send_vector(0, 0, 0);
      send_vector(32767, 32767, 6434);
      send_vector(-32768, -32768, 6434);
      send_vector(-32768, 32767, -6434);
      send_vector(32767, -32768, 19302);
      send_vector(-32768, -32768, -19302);
      send_vector(32767, 0, ANGLE_MAX);
      send_vector(32767, 0, -ANGLE_MAX);
      send_vector(-32768, 32767, ANGLE_MAX);
      send_vector(1000, -2000, FOLD_ANGLE - 1);
      send_vector(1000, -2000, FOLD_ANGLE);
      send_vector(-1000, 2000, -FOLD_ANGLE + 1);
      send_vector(-1000, 2000, -FOLD_ANGLE);
      send_vector(1, 0, 1);
      send_vector(-1, -1, -1);
      send_vector(1, 1, 6434);
      send_vector(-1, 1, 6434);
      send_vector(0, 32767, 12867);
      send_vector(0, -32768, -12868);
      send_vector(12345, -23456, 3000);
      wait_for_results();
   endtask

   task automatic test_stream_no_idling();
      random_vectors(290, 0, 0);
   endtask

   task automatic test_sender_gaps();
      random_vectors(285, 69, 0);
   endtask

   task automatic test_receiver_stalls();
      random_vectors(285, 0, 69);
   endtask

   task automatic test_both_idle();
      random_vectors(290, 19, 19);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_stream_no_idling();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      stall_pct = 0;
      repeat (2*LATENCY) @(posedge clock);
      if (mismatch_count == 0 && expected_rotations.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
